@@ design/swr_pkg.sv @@
// ---------------------------------------------------------------------------
// swr_pkg
// Shared types, constants and control bundles of the sliding window receiver.
// ---------------------------------------------------------------------------
package swr_pkg;

  // Window store geometry (MAX_WINDOW is a power of two)
  localparam int MAX_WINDOW  = 16;
  localparam int MAX_PAYLOAD = 1000;
  localparam int IDX_W       = $clog2(MAX_WINDOW);
  localparam int CNT_W       = IDX_W + 1;
  localparam int CFG_W       = 5;
  localparam int WEFF_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = CFG_W'(3);

  // Packet type codes
  localparam logic [1:0] PKT_START = 2'd0;
  localparam logic [1:0] PKT_FINAL = 2'd3;

  // Result kind codes
  localparam logic RES_ACK     = 1'b0;
  localparam logic RES_DELIVER = 1'b1;

  typedef struct packed {
    logic [1:0]         packet_type;
    logic signed [31:0] seq_num;
    logic [15:0]        pkt_length;
    logic [15:0]        sender_window;
    logic [15:0]        payload_tag;
    logic               checksum_ok;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] ack_seq;
    logic [15:0]        echo_window;
    logic [15:0]        deliver_tag;
    logic [9:0]         deliver_length;
    logic               is_final;
    logic               last_of_run;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_ACK,
    ST_READ,
    ST_DELIV
  } swr_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;
    logic store;
    logic emit_reject;
    logic emit_start;
    logic scan_clr;
    logic scan_step;
    logic emit_ack;
    logic rd_issue;
    logic emit_deliv;
    logic deliv_step;
    logic finish;
  } swr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic done;
    logic bad;
    logic is_start;
    logic scan_hit;
    logic run_empty;
    logic deliv_end;
    logic out_free;
  } swr_sts_t;

endpackage

@@ design/swr_ctrl.sv @@
// ---------------------------------------------------------------------------
// swr_ctrl
// Sequencer of the receiver: classify, store, scan, acknowledge, deliver.
// ---------------------------------------------------------------------------
module swr_ctrl import swr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  swr_sts_t sts,
  output swr_cmd_t cmd
);

  swr_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (sts.done) begin
          state_nxt = ST_IDLE;
        end else if (sts.bad) begin
          if (sts.out_free) begin
            cmd.emit_reject = 1'b1;
            state_nxt       = ST_IDLE;
          end
        end else if (sts.is_start) begin
          if (sts.out_free) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else begin
          cmd.store    = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_hit) begin
          cmd.scan_step = 1'b1;
        end else if (sts.run_empty) begin
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_ACK;
        end
      end
      ST_ACK: begin
        if (sts.out_free) begin
          cmd.emit_ack = 1'b1;
          state_nxt    = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_DELIV;
      end
      ST_DELIV: begin
        if (sts.out_free) begin
          cmd.emit_deliv = 1'b1;
          if (sts.deliv_end) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end else begin
            cmd.deliv_step = 1'b1;
            state_nxt      = ST_READ;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/swr_datapath.sv @@
// ---------------------------------------------------------------------------
// swr_datapath
// Window registers, slot store, run counter and result register.
// ---------------------------------------------------------------------------
module swr_datapath import swr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  in_item_t         in_item,
  input  logic             out_stall,
  output logic             out_valid,
  output out_item_t        out_item,
  input  swr_cmd_t         cmd,
  output swr_sts_t         sts
);

  logic [CFG_W-1:0]       win_size_r;
  in_item_t               in_r;
  logic [31:0]            ws_r;
  logic [31:0]            last_acked_r;
  logic                   done_r;
  logic [MAX_WINDOW-1:0]  slot_valid_r;
  logic [15:0]            slot_tag_mem    [MAX_WINDOW];
  logic [9:0]             slot_len_mem    [MAX_WINDOW];
  logic                   slot_final_mem  [MAX_WINDOW];
  logic [15:0]            rd_tag_r;
  logic [9:0]             rd_len_r;
  logic                   rd_final_r;
  logic [CNT_W-1:0]       scan_cnt_r;
  logic [IDX_W-1:0]       deliv_idx_r;
  logic                   out_valid_r;
  out_item_t              out_item_r;

  logic [WEFF_W-1:0]      weff;
  logic signed [33:0]     seq_ext;
  logic signed [33:0]     lo_ext;
  logic signed [33:0]     hi_ext;
  logic [IDX_W-1:0]       ws_lo;
  logic [IDX_W-1:0]       st_idx;
  logic [IDX_W-1:0]       scan_idx;
  logic [IDX_W-1:0]       rd_idx;
  logic [31:0]            run_top;
  logic                   deliv_last;
  logic                   out_free;

  // Window bounds check
  always_comb begin
    weff = (WEFF_W'(win_size_r) > WEFF_W'(MAX_WINDOW)) ? WEFF_W'(MAX_WINDOW)
                                                       : WEFF_W'(win_size_r);
    seq_ext  = 34'($signed(in_r.seq_num));
    lo_ext   = 34'($signed(ws_r));
    hi_ext   = lo_ext + $signed({1'b0, 33'(weff)});
    ws_lo    = ws_r[IDX_W-1:0];
    st_idx   = in_r.seq_num[IDX_W-1:0];
    scan_idx = ws_lo + scan_cnt_r[IDX_W-1:0];
    rd_idx   = ws_lo + deliv_idx_r;
    run_top  = ws_r + 32'(scan_cnt_r) - 32'd1;
    deliv_last = (CNT_W'(deliv_idx_r) + CNT_W'(1)) == scan_cnt_r;
    out_free = !out_valid_r || !out_stall;
  end

  assign sts.done      = done_r;
  assign sts.bad       = (seq_ext < lo_ext) || (seq_ext >= hi_ext) ||
                         (in_r.pkt_length > 16'(MAX_PAYLOAD)) || !in_r.checksum_ok;
  assign sts.is_start  = (in_r.packet_type == PKT_START);
  assign sts.scan_hit  = !scan_cnt_r[CNT_W-1] && slot_valid_r[scan_idx];
  assign sts.run_empty = (scan_cnt_r == '0);
  assign sts.deliv_end = rd_final_r || deliv_last;
  assign sts.out_free  = out_free;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_size_r <= WINDOW_SIZE_RESET;
    end else if (cfg_wr_en) begin
      win_size_r <= cfg_wr_data;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_item;
    end
  end

  // Window state: advance on start packets and on finished runs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r         <= '0;
      last_acked_r <= '1;
      done_r       <= 1'b0;
    end else if (cmd.emit_start) begin
      ws_r         <= ws_r + 32'd1;
      last_acked_r <= in_r.seq_num;
    end else if (cmd.finish) begin
      ws_r         <= ws_r + 32'(scan_cnt_r);
      last_acked_r <= run_top;
      done_r       <= rd_final_r;
    end
  end

  // Slot valid bits: set on store, drop the whole run on finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r <= '0;
    end else if (cmd.store) begin
      slot_valid_r[st_idx] <= 1'b1;
    end else if (cmd.finish) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if ({1'b0, IDX_W'(j) - ws_lo} < scan_cnt_r) begin
          slot_valid_r[j] <= 1'b0;
        end
      end
    end
  end

  // Slot payload store; duplicates keep the first copy
  always_ff @(posedge clk) begin
    if (cmd.store && !slot_valid_r[st_idx]) begin
      slot_tag_mem[st_idx]   <= in_r.payload_tag;
      slot_len_mem[st_idx]   <= in_r.pkt_length[9:0];
      slot_final_mem[st_idx] <= (in_r.packet_type == PKT_FINAL);
    end
  end

  // Registered slot read
  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_tag_r   <= slot_tag_mem[rd_idx];
      rd_len_r   <= slot_len_mem[rd_idx];
      rd_final_r <= slot_final_mem[rd_idx];
    end
  end

  // Run length counter and delivery index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r  <= '0;
      deliv_idx_r <= '0;
    end else begin
      if (cmd.scan_clr) begin
        scan_cnt_r <= '0;
      end else if (cmd.scan_step) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      if (cmd.emit_ack) begin
        deliv_idx_r <= '0;
      end else if (cmd.deliv_step) begin
        deliv_idx_r <= deliv_idx_r + IDX_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_reject || cmd.emit_start || cmd.emit_ack || cmd.emit_deliv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_reject || cmd.emit_start || cmd.emit_ack) begin
      out_item_r.result_kind    <= RES_ACK;
      out_item_r.echo_window    <= in_r.sender_window;
      out_item_r.deliver_tag    <= '0;
      out_item_r.deliver_length <= '0;
      out_item_r.is_final       <= 1'b0;
      out_item_r.last_of_run    <= !cmd.emit_ack;
      if (cmd.emit_reject) begin
        out_item_r.ack_seq <= last_acked_r;
      end else if (cmd.emit_start) begin
        out_item_r.ack_seq <= in_r.seq_num;
      end else begin
        out_item_r.ack_seq <= run_top;
      end
    end else if (cmd.emit_deliv) begin
      out_item_r.result_kind    <= RES_DELIVER;
      out_item_r.ack_seq        <= '0;
      out_item_r.echo_window    <= '0;
      out_item_r.deliver_tag    <= rd_tag_r;
      out_item_r.deliver_length <= rd_len_r;
      out_item_r.is_final       <= rd_final_r;
      out_item_r.last_of_run    <= rd_final_r || deliv_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ design/sliding_window_receiver_top.sv @@
// ---------------------------------------------------------------------------
// sliding_window_receiver_top
// Selective-repeat receive side with cumulative acknowledgement.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  in        in_valid / in_stall       in_item  (in_item_t)
//  out       out_valid / out_stall     out_item (out_item_t)
//  cfg       cfg_wr_en                 cfg_wr_data (window size)
//
//  One item at a time. A rejected or start packet is ACKed straight from
//  classification; any packet after the transfer is done is dropped. A
//  data packet is stored and the run from the window start is scanned; with
//  no run there is no result. A run of n stored packets is ACKed and then
//  delivered packet by packet (slot store read is registered), up to a full
//  window of 16. Output stalls hold the sequencer until the result register
//  is free. Synchronous reset clears slot valid bits at once; no clearing pass.
// ---------------------------------------------------------------------------
module sliding_window_receiver_top import swr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item
);

  swr_cmd_t cmd;
  swr_sts_t sts;

  swr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  swr_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cmd         (cmd),
    .sts         (sts)
  );

  // Busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous item in progress");

  // At most one result loaded per cycle
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.emit_reject, cmd.emit_start, cmd.emit_ack, cmd.emit_deliv}))
    else $error("several results loaded at once");

  // Never overwrite a waiting result
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_reject || cmd.emit_start || cmd.emit_ack || cmd.emit_deliv)
      |-> sts.out_free)
    else $error("result register overwritten");

  // A run ends only with a delivery
  a_finish_deliv: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> cmd.emit_deliv)
    else $error("run finished without delivery");

endmodule
